>>> rtl/core/ksbd_pkg.sv
// Shared types, constants and the scan-code table for the keyed substitution decoder.
`timescale 1ns / 1ps

package ksbd_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] word_t;

    localparam int unsigned KEY_DEPTH  = 256;
    localparam int unsigned MASK_DEPTH = 16;
    localparam int unsigned VK_DEPTH   = 128;

    localparam byte_t KEY_LAST    = 8'd254;   // final outer position of the exchange sort
    localparam byte_t BYTE_MAX    = 8'd255;
    localparam byte_t UPPER_A     = 8'h41;
    localparam byte_t UPPER_Z     = 8'd90;
    localparam byte_t CASE_OFFSET = 8'h20;

    localparam word_t LCG_MUL = 32'd214013;
    localparam word_t LCG_ADD = 32'd2531011;

    // scan code to virtual key
    localparam byte_t SCAN_TO_VK [VK_DEPTH] = '{
        8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'hbd, 8'hbb, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'hdb, 8'hdd, 8'h0d, 8'h11, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'hba,
        8'hc0, 8'hdf, 8'h10, 8'hde, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'hbc, 8'hbe, 8'hbf, 8'h10, 8'h6a,
        8'h12, 8'h20, 8'h14, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74,
        8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h90, 8'h91, 8'h24,
        8'h26, 8'h21, 8'h6d, 8'h25, 8'h0c, 8'h27, 8'h6b, 8'h23,
        8'h28, 8'h22, 8'h2d, 8'h2e, 8'h2c, 8'h00, 8'hdc, 8'h7a,
        8'h7b, 8'h0c, 8'hee, 8'hf1, 8'hea, 8'hf9, 8'hf5, 8'hf3,
        8'h00, 8'h00, 8'hfb, 8'h2f, 8'h7c, 8'h7d, 8'h7e, 8'h7f,
        8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'hed,
        8'h00, 8'he9, 8'h00, 8'hc1, 8'h00, 8'h00, 8'h87, 8'h00,
        8'h00, 8'h00, 8'h00, 8'heb, 8'h09, 8'h00, 8'hc2, 8'h00
    };

endpackage

>>> rtl/core/ksbd_in_if.sv
// Input channel: one cipher byte request.
`timescale 1ns / 1ps

interface ksbd_in_if
    import ksbd_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t cipher_byte;
    logic  last_in_message;

    modport source (output valid, output cipher_byte, output last_in_message, input ready);
    modport sink   (input valid, input cipher_byte, input last_in_message, output ready);
endinterface

>>> rtl/core/ksbd_out_if.sv
// Output channel: one decoded byte request.
`timescale 1ns / 1ps

interface ksbd_out_if
    import ksbd_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t plain_byte;
    logic  last_out;

    modport source (output valid, output plain_byte, output last_out, input ready);
    modport sink   (input valid, input plain_byte, input last_out, output ready);
endinterface

>>> rtl/core/ksbd_cfg_if.sv
// Configuration channel: seed register write.
`timescale 1ns / 1ps

interface ksbd_cfg_if
    import ksbd_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t seed;

    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

>>> rtl/core/keyed_substitution_byte_decoder_top.sv
// Top level of the keyed substitution byte decoder: key build engine and lookup pipeline.
`timescale 1ns / 1ps
//
// Usage
//   din  : cipher byte requests (cipher_byte, last_in_message), valid/ready.
//   dout : decoded requests (plain_byte, last_out), valid/ready.
//   cfg  : seed writes, always ready. A write stores the seed and restarts
//          the key build. Write only while no request is in flight.
// Key build: starts right after reset and after every seed write; din.ready
//   stays low meanwhile. Steps: a seed load, 16 generator draws
//   (one 32x32 multiply-add per cycle), 256 fill writes, and an exchange sort
//   that walks the key memories one entry per cycle (outer k: read k, compare
//   k+1..255, write k back). The sort speed is set by the single memory read port.
// Decoding: one request per cycle once the key is built, while dout.ready
//   stays high. A request passes the registered read of the symbol memory,
//   then the scan-code table and the output register that drives dout.valid.
// Stall: when dout.ready is low the output register holds, the lookup stage
//   behind it holds, and din.ready drops once both are full.
// Reset: seed, generator and terminator state clear; key memories are not
//   cleared since the build writes every entry before any lookup.

module keyed_substitution_byte_decoder_top
    import ksbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ksbd_in_if.sink     din,
    ksbd_out_if.source  dout,
    ksbd_cfg_if.sink    cfg
);

    localparam logic [2:0] S_SEED  = 3'd0;
    localparam logic [2:0] S_LCG   = 3'd1;
    localparam logic [2:0] S_FILL  = 3'd2;
    localparam logic [2:0] S_KREAD = 3'd3;
    localparam logic [2:0] S_KCAP  = 3'd4;
    localparam logic [2:0] S_SORT  = 3'd5;
    localparam logic [2:0] S_KWB   = 3'd6;
    localparam logic [2:0] S_RUN   = 3'd7;

    localparam logic [8:0] M_END = 9'(KEY_DEPTH);

    // key memories and mask bytes
    byte_t key_symbol_mem [KEY_DEPTH];
    byte_t key_weight_mem [KEY_DEPTH];
    byte_t mask_reg [MASK_DEPTH];

    logic [2:0] state_reg, state_next;
    logic       key_valid_reg, key_valid_next;
    logic       term_reg, term_next;
    word_t      seed_reg, seed_next;
    word_t      gen_reg, gen_next;
    logic [3:0] cnt_reg, cnt_next;
    byte_t      j_reg, j_next;
    byte_t      k_reg, k_next;
    logic [8:0] m_reg, m_next;
    byte_t      cmp_idx_reg, cmp_idx_next;
    byte_t      sk_reg, sk_next;     // symbol held at sort position k
    byte_t      wk_reg, wk_next;     // weight held at sort position k

    byte_t      rd_sym_reg, rd_wt_reg;

    logic       s1_valid_reg, s1_valid_next;
    logic       s1_zero_reg, s1_zero_next;
    logic       s1_last_reg, s1_last_next;
    logic       out_valid_reg, out_valid_next;
    byte_t      out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    logic       mem_we, mem_re, mask_we;
    byte_t      mem_waddr, mem_raddr, mem_wsym, mem_wwt;
    word_t      lcg_val;
    logic       cfg_fire, in_fire, advance, term_eff;
    byte_t      vk, result;
    logic       high_sym;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;

    assign lcg_val = gen_reg * LCG_MUL + LCG_ADD;

    assign advance   = !out_valid_reg || dout.ready;
    assign din.ready = (state_reg == S_RUN) && (!s1_valid_reg || advance);
    assign in_fire   = din.valid && din.ready;
    assign term_eff  = term_reg || (din.cipher_byte == '0);

    // symbol to virtual key, letters lowercased unless the symbol's top bit is set; zero once terminated
    always_comb
    begin
        high_sym = rd_sym_reg[7];
        vk       = SCAN_TO_VK[rd_sym_reg[6:0]];
        result   = vk;
        if (!high_sym && (vk inside {[UPPER_A:UPPER_Z]}))
        begin
            result = vk + CASE_OFFSET;
        end
        if (s1_zero_reg)
        begin
            result = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        key_valid_next = key_valid_reg;
        term_next      = term_reg;
        seed_next      = seed_reg;
        gen_next       = gen_reg;
        cnt_next       = cnt_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        cmp_idx_next   = cmp_idx_reg;
        sk_next        = sk_reg;
        wk_next        = wk_reg;
        s1_valid_next  = s1_valid_reg;
        s1_zero_next   = s1_zero_reg;
        s1_last_next   = s1_last_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mask_we        = 1'b0;
        mem_waddr      = '0;
        mem_raddr      = '0;
        mem_wsym       = '0;
        mem_wwt        = '0;

        case (state_reg)
            S_SEED:
            begin
                gen_next   = seed_reg;
                cnt_next   = '0;
                state_next = S_LCG;
            end
            S_LCG:
            begin
                gen_next = lcg_val;
                mask_we  = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(MASK_DEPTH - 1))
                begin
                    j_next     = '0;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wsym  = j_reg;
                mem_wwt   = (j_reg == '0) ? '0 : (j_reg ^ mask_reg[j_reg[3:0]]);
                j_next    = j_reg + 8'd1;
                if (j_reg == BYTE_MAX)
                begin
                    k_next     = 8'd1;
                    state_next = S_KREAD;
                end
            end
            S_KREAD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = k_reg;
                m_next     = {1'b0, k_reg} + 9'd1;
                state_next = S_KCAP;
            end
            S_KCAP:
            begin
                sk_next      = rd_sym_reg;
                wk_next      = rd_wt_reg;
                mem_re       = 1'b1;
                mem_raddr    = m_reg[7:0];
                cmp_idx_next = m_reg[7:0];
                m_next       = m_reg + 9'd1;
                state_next   = S_SORT;
            end
            S_SORT:
            begin
                // exchange with the entry just read when it outweighs position k
                if (wk_reg < rd_wt_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cmp_idx_reg;
                    mem_wsym  = sk_reg;
                    mem_wwt   = wk_reg;
                    sk_next   = rd_sym_reg;
                    wk_next   = rd_wt_reg;
                end
                if (m_reg != M_END)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = m_reg[7:0];
                    cmp_idx_next = m_reg[7:0];
                    m_next       = m_reg + 9'd1;
                end
                else
                begin
                    state_next = S_KWB;
                end
            end
            S_KWB:
            begin
                mem_we    = 1'b1;
                mem_waddr = k_reg;
                mem_wsym  = sk_reg;
                mem_wwt   = wk_reg;
                if (k_reg == KEY_LAST)
                begin
                    key_valid_next = 1'b1;
                    state_next     = S_RUN;
                end
                else
                begin
                    k_next     = k_reg + 8'd1;
                    state_next = S_KREAD;
                end
            end
            S_RUN:
            begin
                if (in_fire)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = din.cipher_byte;
                    s1_zero_next = term_eff;
                    s1_last_next = din.last_in_message;
                    term_next    = din.last_in_message ? 1'b0 : term_eff;
                end
            end
            default:
            begin
                state_next = S_SEED;
            end
        endcase

        // lookup stage and output register
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
            out_byte_next  = result;
            out_last_next  = s1_last_reg;
        end
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        if (cfg_fire)
        begin
            seed_next      = cfg.seed;
            key_valid_next = 1'b0;
            state_next     = S_SEED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SEED;
            key_valid_reg <= 1'b0;
            term_reg      <= 1'b0;
            seed_reg      <= '0;
            gen_reg       <= '0;
            cnt_reg       <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            m_reg         <= '0;
            cmp_idx_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_valid_reg <= key_valid_next;
            term_reg      <= term_next;
            seed_reg      <= seed_next;
            gen_reg       <= gen_next;
            cnt_reg       <= cnt_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            m_reg         <= m_next;
            cmp_idx_reg   <= cmp_idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sk_reg       <= sk_next;
        wk_reg       <= wk_next;
        s1_zero_reg  <= s1_zero_next;
        s1_last_reg  <= s1_last_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        if (mask_we)
        begin
            mask_reg[cnt_reg] <= lcg_val[23:16];
        end
    end

    // key memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_symbol_mem[mem_waddr] <= mem_wsym;
            key_weight_mem[mem_waddr] <= mem_wwt;
        end
        if (mem_re)
        begin
            rd_sym_reg <= key_symbol_mem[mem_raddr];
            rd_wt_reg  <= key_weight_mem[mem_raddr];
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.plain_byte = out_byte_reg;
    assign dout.last_out   = out_last_reg;

    // requests are taken only with a finished key
    assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |-> (key_valid_reg && state_reg == S_RUN))
        else $error("request accepted during key build");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) == key_valid_reg)
        else $error("key valid flag out of step with sequencer");

    // a stalled lookup stage keeps its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !dout.ready) |=> s1_valid_reg)
        else $error("lookup stage dropped a request under stall");

    // the sort only compares entries beyond position k
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SORT) |-> (cmp_idx_reg > k_reg))
        else $error("sort compare index not above k");

endmodule

>>> test/ksbd_checker.sv
// Checker for the keyed substitution byte decoder: predicts each decoded request and compares.
`timescale 1ns / 1ps

module ksbd_checker
    import ksbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ksbd_in_if   din,
    ksbd_out_if  dout,
    ksbd_cfg_if  cfg,
    output int   fail_count,
    output int   pending_count,
    output int   checked_count
);

    localparam byte_t TERMINATOR = 8'h00;

    typedef struct packed {
        byte_t plain;
        logic  last;
    } decoded_t;

    // shadow of the block's state
    word_t    seed_shadow;
    logic     key_ready;
    logic     msg_ended;
    byte_t    key_sym [KEY_DEPTH];
    byte_t    key_wt  [KEY_DEPTH];
    decoded_t decoded_q [$];
    int       n_err;
    int       n_checked;

    // mask draw, fill and descending exchange sort on the weights
    function automatic void rebuild_key_table();
        word_t lcg;
        byte_t mask [MASK_DEPTH];
        byte_t t;
        lcg = seed_shadow;
        for (int i = 0; i < MASK_DEPTH; i++) begin
            lcg     = lcg * LCG_MUL + LCG_ADD;
            mask[i] = lcg[23:16];
        end
        key_sym[0] = '0;
        key_wt[0]  = '0;
        for (int j = 1; j < KEY_DEPTH; j++) begin
            key_sym[j] = byte_t'(j);
            key_wt[j]  = byte_t'(j) ^ mask[j % MASK_DEPTH];
        end
        for (int k = 1; k <= KEY_LAST; k++) begin
            for (int m = k + 1; m < KEY_DEPTH; m++) begin
                if (key_wt[k] < key_wt[m]) begin
                    t          = key_sym[k];
                    key_sym[k] = key_sym[m];
                    key_sym[m] = t;
                    t          = key_wt[k];
                    key_wt[k]  = key_wt[m];
                    key_wt[m]  = t;
                end
            end
        end
        key_ready = 1'b1;
    endfunction

    function automatic byte_t lookup_vk(input byte_t cipher);
        byte_t sym;
        byte_t vk;
        sym = key_sym[cipher];
        vk  = SCAN_TO_VK[sym[6:0]];
        // symbols with the top bit set skip lowercasing
        if (!sym[7] && vk >= UPPER_A && vk <= UPPER_Z)
            vk = vk + CASE_OFFSET;
        return vk;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        decoded_t want;
        if (!rst_n) begin
            seed_shadow = '0;
            key_ready   = 1'b0;
            msg_ended   = 1'b0;
            decoded_q.delete();
            n_err       = 0;
            n_checked   = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                seed_shadow = cfg.seed;
                key_ready   = 1'b0;
            end

            if (dout.valid && dout.ready) begin
                if (decoded_q.size() == 0) begin
                    n_err++;
                    $display("%0t: unexpected request plain_byte=%h last_out=%b",
                             $time, dout.plain_byte, dout.last_out);
                end else begin
                    want = decoded_q.pop_front();
                    n_checked++;
                    if (dout.plain_byte !== want.plain) begin
                        n_err++;
                        $display("%0t: plain_byte expected %h actual %h",
                                 $time, want.plain, dout.plain_byte);
                    end
                    if (dout.last_out !== want.last) begin
                        n_err++;
                        $display("%0t: last_out expected %b actual %b",
                                 $time, want.last, dout.last_out);
                    end
                end
            end

            if (din.valid && din.ready) begin
                if (!key_ready)
                    rebuild_key_table();
                if (din.cipher_byte == TERMINATOR)
                    msg_ended = 1'b1;
                want.plain = msg_ended ? TERMINATOR : lookup_vk(din.cipher_byte);
                want.last  = din.last_in_message;
                if (din.last_in_message)
                    msg_ended = 1'b0;
                decoded_q.push_back(want);
            end
        end
        fail_count    <= n_err;
        pending_count <= decoded_q.size();
        checked_count <= n_checked;
    end

endmodule

>>> test/tb_keyed_substitution_byte_decoder_top.sv
// Testbench top for the keyed substitution byte decoder: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb_keyed_substitution_byte_decoder_top
    import ksbd_pkg::*;
();

    localparam int    CLK_PERIOD    = 10;
    localparam byte_t TERMINATOR    = 8'h00;
    localparam int    PHASE_ITEMS   = 185;
    // settling margin after the last decoded request, so that nothing trails
    localparam int    SETTLE_CYCLES = 8;

    logic clk;
    logic rst_n;

    ksbd_in_if  din_ch ();
    ksbd_out_if dout_ch ();
    ksbd_cfg_if cfg_ch ();

    int chk_errors;
    int chk_pending;
    int chk_checked;

    int items_sent;
    int seeds_written;
    int burst_left;

    keyed_substitution_byte_decoder_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_ch),
        .dout  (dout_ch),
        .cfg   (cfg_ch)
    );

    ksbd_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .din           (din_ch),
        .dout          (dout_ch),
        .cfg           (cfg_ch),
        .fail_count    (chk_errors),
        .pending_count (chk_pending),
        .checked_count (chk_checked)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Output side backpressure. The mode rotates with a free-running cycle
    // counter so that stalls land on every phase: always ready, light random
    // stalls, a fixed on/off rhythm, and heavy random stalls.
    initial
    begin
        logic [8:0] stall_cyc;
        stall_cyc     = '0;
        dout_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall_cyc = stall_cyc + 1'b1;
            case (stall_cyc[8:7])
                2'd0: dout_ch.ready = 1'b1;
                2'd1: dout_ch.ready = ($urandom_range(0, 3) != 0);
                2'd2: dout_ch.ready = (stall_cyc[1:0] != 2'd3);
                default: dout_ch.ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Drop valid and put junk on the payload, so that a
    // request taken without valid would show up as a mismatch.
    task automatic hold_off(input int n);
        for (int i = 0; i < n; i++)
        begin
            @(negedge clk);
            din_ch.valid           = 1'b0;
            din_ch.cipher_byte     = byte_t'($urandom);
            din_ch.last_in_message = 1'($urandom);
        end
    endtask

    // One request; valid stays high into the next call when bursting.
    task automatic push_request(input byte_t b, input logic last);
        @(negedge clk);
        din_ch.valid           = 1'b1;
        din_ch.cipher_byte     = b;
        din_ch.last_in_message = last;
        @(posedge clk);
        while (!din_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Bursty sender: short bursts behind random gaps, now and then a long
    // stretch with no gap at all.
    task automatic send_byte(input byte_t b, input logic last);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                burst_left = $urandom_range(40, 120);
            end
            else
            begin
                hold_off($urandom_range(1, 6));
                burst_left = $urandom_range(1, 12);
            end
        end
        push_request(b, last);
        burst_left--;
    endtask

    // Wait until every decoded request has come back, then let the pipe settle.
    task automatic drain_decoder();
        hold_off(1);
        while (chk_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // Seed writes only with the decoder empty; the key rebuild that follows
    // keeps din.ready low, which the sender simply waits out.
    task automatic write_seed(input word_t value);
        drain_decoder();
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.seed  = value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        seeds_written++;
    endtask

    // Random messages: mostly well-formed (nonzero text closed by last),
    // a third of them cut short by a terminator, plus stray zeros and
    // stray last flags as noise. Every so often the sender waits for all
    // results before going on.
    task automatic run_messages(input int n_items);
        int    done;
        int    len;
        int    zero_at;
        byte_t b;
        logic  last;
        done = 0;
        while (done < n_items)
        begin
            len     = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(1, 12);
            zero_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len - 1) : -1;
            for (int i = 0; i < len; i++)
            begin
                b = (i == zero_at) ? TERMINATOR : byte_t'($urandom_range(1, 255));
                if ($urandom_range(0, 29) == 0)
                    b = byte_t'($urandom_range(0, 255));
                last = (i == len - 1) ? 1'b1 : ($urandom_range(0, 39) == 0);
                send_byte(b, last);
                done++;
            end
            if ($urandom_range(0, 49) == 0)
                drain_decoder();
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        din_ch.valid           = 1'b0;
        din_ch.cipher_byte     = '0;
        din_ch.last_in_message = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.seed            = '0;
        items_sent             = 0;
        seeds_written          = 0;
        burst_left             = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, on the reset seed. Field extremes and both ends of the
        // byte range, high and low symbols, then terminator handling:
        // an empty message, a terminator mid-message (rest must read 0),
        // a message right after one that was cut (state must be clear),
        // and back-to-back terminators at the head of a message.
        send_byte(8'h01, 1'b0);
        send_byte(BYTE_MAX, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7f, 1'b1);
        send_byte(TERMINATOR, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(TERMINATOR, 1'b0);
        send_byte(BYTE_MAX, 1'b0);
        send_byte(8'h5a, 1'b1);
        send_byte(BYTE_MAX, 1'b0);
        send_byte(8'haa, 1'b1);
        send_byte(TERMINATOR, 1'b0);
        send_byte(TERMINATOR, 1'b0);
        send_byte(8'h33, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'h2a, 1'b1);
        send_byte(8'hc3, 1'b1);

        run_messages(PHASE_ITEMS);

        // Seed settings: both extremes, a return to zero (the reset seed after
        // the all-ones seed), a typical name sum, the top bit alone,
        // and a random one.
        write_seed(32'hffff_ffff);
        run_messages(PHASE_ITEMS);
        write_seed(32'h0000_0000);
        run_messages(PHASE_ITEMS);
        write_seed(32'd1093);
        run_messages(PHASE_ITEMS);
        write_seed(32'h8000_0000);
        run_messages(PHASE_ITEMS);
        write_seed(word_t'($urandom));
        run_messages(PHASE_ITEMS);

        drain_decoder();

        $display("run covered %0d cipher requests under %0d seed writes plus the reset seed,",
                 items_sent, seeds_written);
        $display("with %0d decoded requests compared against the prediction", chk_checked);
        if (chk_errors == 0)
            $display("tb_keyed_substitution_byte_decoder_top: done, clean");
        else
            $display("tb_keyed_substitution_byte_decoder_top: done, errors");
        $finish;
    end

    // Watchdog: six key builds (reset plus five seed writes) plus the traffic
    // fit well inside this several times over.
    initial
    begin
        #10_000_000;
        $display("tb_keyed_substitution_byte_decoder_top: done, errors");
        $finish;
    end

endmodule
